### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### src/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg
// Types, codes and helper functions of the programmable CRC engine.
// ----------------------------------------------------------------------------
package pce_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned DigitW = 4;

  localparam logic [DataW-1:0] InvWide   = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0] InvNarrow = 32'h0000_FFFF;

  typedef enum logic [2:0] {
    CFG_POLY            = 3'd0,
    CFG_WIDE_MODE       = 3'd1,
    CFG_SEED_WRITE      = 3'd2,
    CFG_FINAL_INVERT    = 3'd3,
    CFG_WRITE_TRANSPOSE = 3'd4,
    CFG_READ_TRANSPOSE  = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    TR_NONE  = 2'd0,
    TR_BITS  = 2'd1,
    TR_ALL   = 2'd2,
    TR_BYTES = 2'd3
  } transpose_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic [DataW-1:0] poly;
    logic             wide_mode;
    logic             seed_write;
    logic             final_invert;
    logic [1:0]       write_transpose;
    logic [1:0]       read_transpose;
  } cfg_t;

  // Command from the control side to the CRC core.
  typedef struct packed {
    logic             start;
    logic             load_seed;
    logic [DataW-1:0] data;
    logic [1:0]       offset;
    logic [2:0]       size;
  } core_cmd_t;

  // Byte-lane mask for an access of n bytes (n of 4 or more is the whole word).
  function automatic logic [DataW-1:0] size_mask(input logic [2:0] n);
    logic [DataW-1:0] m;
    case (n)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Transpose over the low n bytes, n in 1 to 4.
  function automatic logic [DataW-1:0] transpose(input logic [DataW-1:0] v,
                                                 input logic [2:0] n,
                                                 input logic [1:0] mode);
    logic [DataW-1:0] res;
    logic [DataW-1:0] masked;
    logic [DataW-1:0] rev;
    logic [2:0]       pad;
    logic [4:0]       sh;
    masked = v & size_mask(n);
    pad    = 3'd4 - n;
    sh     = {pad[1:0], 3'b000};
    res    = '0;
    rev    = '0;
    case (mode)
      TR_BITS: begin
        for (int i = 0; i < 4; i++) begin
          for (int b = 0; b < 8; b++) begin
            res[i*8+b] = masked[i*8+7-b];
          end
        end
      end
      TR_ALL: begin
        for (int b = 0; b < 32; b++) begin
          rev[b] = masked[31-b];
        end
        res = rev >> sh;
      end
      TR_BYTES: begin
        for (int i = 0; i < 4; i++) begin
          rev[i*8 +: 8] = masked[(3-i)*8 +: 8];
        end
        res = rev >> sh;
      end
      default: res = v;
    endcase
    return res;
  endfunction

endpackage

### src/programmable_crc_engine.sv
// ----------------------------------------------------------------------------
// programmable_crc_engine
// Data port of a CRC peripheral with programmable 16/32-bit polynomial.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------
//   in      | in_valid / in_stall | operation, byte_offset, access_size,
//           |                     | write_data
//   out     | out_valid/out_stall | read_data
//   cfg     | cfg_write           | cfg_index, cfg_data
//
// A read or a seed write leaves the engine free. A compute write feeds its
// data through the CRC one nibble per cycle and keeps the engine busy
// until all 2 * access_size nibbles are shifted, so no new word is taken
// before then; that nibble loop in the CRC core sets the rate. Reset clears
// the CRC register and all configuration. A word is taken only when the
// engine is free and the output register is empty or being emptied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module programmable_crc_engine (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [1:0]  byte_offset,
  input  logic [2:0]  access_size,
  input  logic [31:0] write_data,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,

  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pce_pkg::cfg_t      cfg;
  pce_pkg::core_cmd_t cmd;
  logic               busy;
  logic [31:0]        crc;
  logic [31:0]        fmt_data;
  logic               in_accept;
  logic               size_ok;

  // The engine is held off while a compute write is still shifting, and
  // while a finished word sits unclaimed in the output register.
  assign in_stall  = busy || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign size_ok   = access_size inside {[3'd1:3'd4]};

  // Configuration registers. Writes to indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pce_pkg::CFG_POLY:            cfg.poly            <= cfg_data;
        pce_pkg::CFG_WIDE_MODE:       cfg.wide_mode       <= cfg_data[0];
        pce_pkg::CFG_SEED_WRITE:      cfg.seed_write      <= cfg_data[0];
        pce_pkg::CFG_FINAL_INVERT:    cfg.final_invert    <= cfg_data[0];
        pce_pkg::CFG_WRITE_TRANSPOSE: cfg.write_transpose <= cfg_data[1:0];
        pce_pkg::CFG_READ_TRANSPOSE:  cfg.read_transpose  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Writes with a bad access size are dropped; seed mode merges the data
  // into the register, otherwise the core starts shifting nibbles.
  always_comb begin
    cmd.data      = write_data;
    cmd.offset    = byte_offset;
    cmd.size      = access_size;
    cmd.start     = in_accept && (operation == pce_pkg::OP_WRITE) && size_ok
                    && !cfg.seed_write;
    cmd.load_seed = in_accept && (operation == pce_pkg::OP_WRITE) && size_ok
                    && cfg.seed_write;
  end

  pce_crc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .cmd  (cmd),
    .busy (busy),
    .crc  (crc)
  );

  pce_read_fmt u_read_fmt (
    .cfg    (cfg),
    .crc    (crc),
    .offset (byte_offset),
    .size   (access_size),
    .data   (fmt_data)
  );

  // Output register: every accepted word gives one result word, and a
  // write always answers with zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_data <= (operation == pce_pkg::OP_READ) ? fmt_data : 32'd0;
    end
  end

  // A write access always yields a zero result word in the next cycle.
  `ASSERT_NEXT(a_write_zero, clk, rst, in_accept && (operation == pce_pkg::OP_WRITE),
               out_valid && (read_data == 32'd0), "write did not return zero")

  // A compute write keeps the core busy in the cycle after it is taken.
  `ASSERT_NEXT(a_start_busy, clk, rst, cmd.start, busy && in_stall,
               "compute write did not occupy the core")

  // After a 16-bit compute write the upper half of the register is clear.
  `ASSERT_HOLDS(a_narrow_upper, clk, rst,
                !($fell(busy) && !$past(cfg.wide_mode)) || (crc[31:16] == 16'd0),
                "upper CRC bits set after 16-bit computation")

endmodule

### src/pce_crc_core.sv
// ----------------------------------------------------------------------------
// pce_crc_core
// CRC register with a nibble-serial update unit and seed merge.
// ----------------------------------------------------------------------------
module pce_crc_core (
  input  logic                         clk,
  input  logic                         rst,
  input  pce_pkg::cfg_t                cfg,
  input  pce_pkg::core_cmd_t           cmd,
  output logic                         busy,
  output logic [pce_pkg::DataW-1:0]    crc
);

  logic [pce_pkg::DataW-1:0] crc_value;
  logic [pce_pkg::DataW-1:0] crc_value_next;
  logic [pce_pkg::DataW-1:0] shreg;
  logic [3:0]                nib_left;

  logic [pce_pkg::DataW-1:0] wmask;
  logic [pce_pkg::DataW-1:0] poly_m;
  logic [pce_pkg::DataW-1:0] step_crc;
  logic [pce_pkg::DataW-1:0] seed_mask;
  logic [pce_pkg::DataW-1:0] aligned;
  logic [2:0]                pad;
  logic                      fb;

  assign busy = (nib_left != 4'd0);
  assign crc  = crc_value;

  // One nibble of the message, MSB first, through the CRC.
  always_comb begin
    wmask    = cfg.wide_mode ? pce_pkg::InvWide : pce_pkg::InvNarrow;
    poly_m   = cfg.poly & wmask;
    step_crc = crc_value;
    fb       = 1'b0;
    for (int j = pce_pkg::DigitW - 1; j >= 0; j--) begin
      fb       = (cfg.wide_mode ? step_crc[31] : step_crc[15])
                 ^ shreg[pce_pkg::DataW - pce_pkg::DigitW + j];
      step_crc = (step_crc << 1) & wmask;
      if (fb) begin
        step_crc = step_crc ^ poly_m;
      end
    end
  end

  always_comb begin
    seed_mask = (cmd.size == 3'd4) ? pce_pkg::InvWide
                : (pce_pkg::size_mask(cmd.size) << {cmd.offset, 3'b000});
    pad       = 3'd4 - cmd.size;
    aligned   = pce_pkg::transpose(cmd.data, cmd.size, cfg.write_transpose)
                << {pad[1:0], 3'b000};
    crc_value_next = crc_value;
    if (busy) begin
      crc_value_next = step_crc;
    end else if (cmd.load_seed) begin
      crc_value_next = (crc_value & ~seed_mask)
                       | ((cmd.data << {cmd.offset, 3'b000}) & seed_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value <= '0;
      nib_left  <= 4'd0;
    end else begin
      crc_value <= crc_value_next;
      if (busy) begin
        nib_left <= nib_left - 4'd1;
      end else if (cmd.start) begin
        nib_left <= {cmd.size, 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      shreg <= shreg << pce_pkg::DigitW;
    end else if (cmd.start) begin
      shreg <= aligned;
    end
  end

endmodule

### src/pce_read_fmt.sv
// ----------------------------------------------------------------------------
// pce_read_fmt
// Read path: transpose, final inversion, lane shift and size mask.
// ----------------------------------------------------------------------------
module pce_read_fmt (
  input  pce_pkg::cfg_t             cfg,
  input  logic [pce_pkg::DataW-1:0] crc,
  input  logic [1:0]                offset,
  input  logic [2:0]                size,
  output logic [pce_pkg::DataW-1:0] data
);

  logic [pce_pkg::DataW-1:0] v;

  always_comb begin
    v = pce_pkg::transpose(crc, 3'd4, cfg.read_transpose);
    if (cfg.final_invert) begin
      v = v ^ (cfg.wide_mode ? pce_pkg::InvWide : pce_pkg::InvNarrow);
    end
    v = v >> {offset, 3'b000};
    if (size inside {[3'd1:3'd4]}) begin
      data = v & pce_pkg::size_mask(size);
    end else begin
      data = '0;
    end
  end

endmodule

### sim/crc_port_checker.sv
// ----------------------------------------------------------------------------
// crc_port_checker
// Watches the data port and register writes of the CRC engine, predicts
// every read_data word and compares it with the word the engine returns.
// ----------------------------------------------------------------------------
module crc_port_checker
  import pce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        operation,
  input  logic [1:0]  byte_offset,
  input  logic [2:0]  access_size,
  input  logic [31:0] write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] read_data,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned words_checked
);

  // Mirror of the engine's registers and CRC state.
  logic [31:0] crc_reg;
  logic [31:0] poly_reg;
  logic        wide;
  logic        seed_mode;
  logic        invert_out;
  transpose_t  wr_tr;
  transpose_t  rd_tr;

  logic [31:0] expected_words[$];
  int unsigned fail_total;
  int unsigned checked_total;

  function automatic logic [31:0] lane_mask(logic [2:0] size);
    return (size >= 3'd4) ? 32'hFFFF_FFFF : (32'd1 << (size * 8)) - 32'd1;
  endfunction

  // Reorders the low nbytes bytes of v; bits above them come out as zero,
  // except when no reordering is selected.
  function automatic logic [31:0] reorder(logic [31:0] v, int unsigned nbytes,
                                          transpose_t mode);
    logic [31:0] r;
    r = '0;
    case (mode)
      TR_BITS: begin
        for (int i = 0; i < nbytes * 8; i++) r[i] = v[(i & ~7) | (7 - (i & 7))];
      end
      TR_ALL: begin
        for (int i = 0; i < nbytes * 8; i++) r[i] = v[nbytes * 8 - 1 - i];
      end
      TR_BYTES: begin
        for (int i = 0; i < nbytes; i++) r[(nbytes - 1 - i) * 8 +: 8] = v[i * 8 +: 8];
      end
      default: r = v;
    endcase
    return r;
  endfunction

  // Applies one bus access to the mirrored CRC register and returns the
  // read_data word it must produce.
  function automatic logic [31:0] take_access(op_t op, logic [1:0] off,
                                              logic [2:0] size, logic [31:0] data);
    logic [31:0] word;
    logic [31:0] lanes;
    logic [31:0] wmask;
    logic [31:0] gpoly;
    int unsigned nbits;
    logic        fb;
    if (size == 3'd0 || size > 3'd4) return '0;
    if (op == OP_READ) begin
      word = reorder(crc_reg, 4, rd_tr);
      if (invert_out) word ^= wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
      return (word >> (off * 8)) & lane_mask(size);
    end
    if (seed_mode) begin
      lanes = (size == 3'd4) ? 32'hFFFF_FFFF : lane_mask(size) << (off * 8);
      crc_reg = (crc_reg & ~lanes) | ((data << (off * 8)) & lanes);
      return '0;
    end
    wmask = wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    gpoly = poly_reg & wmask;
    word = reorder(data, size, wr_tr);
    nbits = size * 8;
    for (int i = nbits - 1; i >= 0; i--) begin
      fb = (wide ? crc_reg[31] : crc_reg[15]) ^ word[i];
      crc_reg = (crc_reg << 1) & wmask;
      if (fb) crc_reg ^= gpoly;
    end
    return '0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      crc_reg = '0;
      poly_reg = '0;
      wide = 1'b0;
      seed_mode = 1'b0;
      invert_out = 1'b0;
      wr_tr = TR_NONE;
      rd_tr = TR_NONE;
      expected_words.delete();
      fail_total = 0;
      checked_total = 0;
    end else begin
      // The returned word belongs to an earlier access, so it is matched
      // before this edge's access is added.
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("read_data %08h returned with no word expected", read_data);
        end else begin
          if (read_data !== expected_words[0]) begin
            fail_total++;
            if (fail_total <= 10)
              $display("read_data of word %0d: expected %08h, got %08h",
                       checked_total, expected_words[0], read_data);
          end
          void'(expected_words.pop_front());
          checked_total++;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_POLY:            poly_reg = cfg_data;
          CFG_WIDE_MODE:       wide = cfg_data[0];
          CFG_SEED_WRITE:      seed_mode = cfg_data[0];
          CFG_FINAL_INVERT:    invert_out = cfg_data[0];
          CFG_WRITE_TRANSPOSE: wr_tr = transpose_t'(cfg_data[1:0]);
          CFG_READ_TRANSPOSE:  rd_tr = transpose_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_words.push_back(take_access(op_t'(operation), byte_offset,
                                             access_size, write_data));
    end
    mismatches <= fail_total;
    pending <= expected_words.size();
    words_checked <= checked_total;
  end

endmodule

### sim/programmable_crc_engine_test.sv
// ----------------------------------------------------------------------------
// programmable_crc_engine_test
// Drives bus accesses and register writes into the CRC engine data port.
// A directed sequence covers seed loads, offsets, access sizes and invalid
// sizes; random phases then sweep polynomials, widths and transposes under
// random idling on both sides. A checker beside the engine does the scoring.
// ----------------------------------------------------------------------------
module programmable_crc_engine_test;
  import pce_pkg::*;

  // CycleLimit leaves ample margin over the slowest correct run.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomPhases = 12;
  localparam int unsigned WordsPerPhase = 150;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        operation;
  logic [1:0]  byte_offset;
  logic [2:0]  access_size;
  logic [31:0] write_data;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_data;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned words_checked;

  // When steady is set neither side idles, giving back-to-back stretches.
  bit          steady;
  // A nonzero value asks the receiver to hold off for that many cycles.
  int unsigned hold_request;
  int unsigned words_offered;
  int unsigned setups_loaded;

  programmable_crc_engine DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .byte_offset (byte_offset),
    .access_size (access_size),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  crc_port_checker port_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .byte_offset   (byte_offset),
    .access_size   (access_size),
    .write_data    (write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("programmable_crc_engine: mismatch");
    $finish;
  end

  // Receiver. After each word it takes, it draws how many cycles to stall
  // before the next one. A hold request from the stimulus side is counted
  // down here, cycle by cycle, while the sender keeps offering words.
  bit          took_word;
  int unsigned stall_left;
  int unsigned hold_left;

  always @(posedge clk) took_word <= out_valid && !out_stall;

  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (took_word) stall_left = steady ? 0 : $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one word after a random gap, none when steady is set, and
  // returns at the edge where the engine takes it. This task only lowers
  // valid in a gap, so it never gets two updates at the same falling edge.
  task automatic offer_word(op_t op, logic [1:0] off, logic [2:0] size,
                            logic [31:0] data);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    byte_offset <= off;
    access_size <= size;
    write_data <= data;
    do @(posedge clk); while (in_stall);
    words_offered++;
  endtask

  // Stops offering and waits until every predicted word has come back,
  // then allows for a compute write still running its nibble loop.
  task automatic drain_port();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Registers are only written while the port is drained.
  task automatic load_setup(logic [31:0] poly, bit wide, bit seed, bit inv,
                            transpose_t wr_tr, transpose_t rd_tr);
    drain_port();
    write_reg(CFG_POLY, poly);
    write_reg(CFG_WIDE_MODE, {31'd0, wide});
    write_reg(CFG_SEED_WRITE, {31'd0, seed});
    write_reg(CFG_FINAL_INVERT, {31'd0, inv});
    write_reg(CFG_WRITE_TRANSPOSE, {30'd0, wr_tr});
    write_reg(CFG_READ_TRANSPOSE, {30'd0, rd_tr});
    @(negedge clk);
    cfg_write <= 1'b0;
    setups_loaded++;
  endtask

  // One random access. About one in ten uses an invalid size; the range
  // 5..8 truncated to three bits gives 5, 6, 7 and 0.
  task automatic offer_random_access();
    op_t         op;
    logic [2:0]  size;
    logic [31:0] data;
    op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    if ($urandom_range(0, 9) == 0) size = 3'($urandom_range(5, 8));
    else size = 3'($urandom_range(1, 4));
    case ($urandom_range(0, 7))
      0: data = 32'h0000_0000;
      1: data = 32'hFFFF_FFFF;
      default: data = $urandom();
    endcase
    offer_word(op, 2'($urandom_range(0, 3)), size, data);
  endtask

  initial begin
    int unsigned phase;
    int unsigned k;
    logic [31:0] poly;
    transpose_t  rd_tr;

    rst = 1'b1;
    in_valid = 1'b0;
    operation = 1'b0;
    byte_offset = '0;
    access_size = '0;
    write_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    hold_request = 0;
    words_offered = 0;
    setups_loaded = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Seed loads in 32-bit mode: a full word, a single byte at the top lane,
    // a halfword whose upper lane falls off the word, and a full word at an
    // offset that loses its top lanes. Reads then pick out three-byte and
    // single-byte slices, and invalid sizes must do nothing.
    load_setup(32'h04C1_1DB7, 1'b1, 1'b1, 1'b0, TR_NONE, TR_NONE);
    offer_word(OP_WRITE, 2'd0, 3'd4, 32'hFFFF_FFFF);
    offer_word(OP_READ,  2'd0, 3'd4, 32'h0000_0000);
    offer_word(OP_WRITE, 2'd3, 3'd1, 32'h0000_00A5);
    offer_word(OP_WRITE, 2'd3, 3'd2, 32'h0000_1234);
    offer_word(OP_WRITE, 2'd2, 3'd4, 32'h1234_5678);
    offer_word(OP_READ,  2'd1, 3'd3, 32'hFFFF_FFFF);
    offer_word(OP_READ,  2'd3, 3'd1, 32'h0000_0000);
    offer_word(OP_WRITE, 2'd1, 3'd0, 32'hFFFF_FFFF);
    offer_word(OP_READ,  2'd0, 3'd5, 32'h0000_0000);
    offer_word(OP_WRITE, 2'd0, 3'd7, 32'hDEAD_BEEF);
    offer_word(OP_READ,  2'd2, 3'd6, 32'h0000_0000);

    // Compute writes with an all-ones polynomial: data above the access size
    // and the offset must both be ignored.
    load_setup(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, TR_BITS, TR_ALL);
    offer_word(OP_WRITE, 2'd2, 3'd1, 32'hFFFF_FF00);
    offer_word(OP_WRITE, 2'd1, 3'd2, 32'h0000_A55A);
    offer_word(OP_WRITE, 2'd3, 3'd3, 32'h0012_3456);
    offer_word(OP_WRITE, 2'd0, 3'd4, 32'hFFFF_FFFF);
    offer_word(OP_READ,  2'd0, 3'd4, 32'h0000_0000);
    offer_word(OP_READ,  2'd2, 3'd2, 32'h0000_0000);

    // 16-bit mode: a seed can leave the upper half set and a read shows it;
    // the first compute write clears it again.
    load_setup(32'h0000_1021, 1'b0, 1'b1, 1'b1, TR_ALL, TR_BYTES);
    offer_word(OP_WRITE, 2'd0, 3'd4, 32'hDEAD_BEEF);
    offer_word(OP_READ,  2'd0, 3'd4, 32'h0000_0000);
    load_setup(32'h0000_1021, 1'b0, 1'b0, 1'b0, TR_BYTES, TR_BITS);
    offer_word(OP_READ,  2'd0, 3'd4, 32'h0000_0000);
    offer_word(OP_WRITE, 2'd0, 3'd3, 32'h00AB_CDEF);
    offer_word(OP_READ,  2'd0, 3'd4, 32'h0000_0000);
    offer_word(OP_WRITE, 2'd1, 3'd1, 32'h0000_0000);
    offer_word(OP_READ,  2'd1, 3'd2, 32'h0000_0000);

    // Random phases. Each phase loads a new setup: the first two use the
    // zero and all-ones polynomials, then common CRC polynomials, then
    // random ones. Width, inversion and both transposes cycle through all
    // codes; every fourth phase runs in seed mode to scatter the CRC state.
    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: poly = 32'h0000_0000;
        1: poly = 32'hFFFF_FFFF;
        2: poly = 32'h0000_8005;
        3: poly = 32'h04C1_1DB7;
        4: poly = 32'h0000_1021;
        default: poly = $urandom();
      endcase
      rd_tr = (phase < 4) ? transpose_t'(3 - phase) : transpose_t'($urandom_range(0, 3));
      steady = 1'b0;
      load_setup(poly, phase[0], (phase % 4) == 2, phase[1], transpose_t'(phase % 4),
                 rd_tr);
      steady = (phase % 5) == 4;
      // In one phase the receiver goes quiet for a long stretch so the
      // engine's output backs up and it stalls the sender.
      if (phase == 3) hold_request = 200;
      for (k = 0; k < WordsPerPhase; k++) begin
        // In another the sender stops mid-phase until the port is empty.
        if (phase == 6 && k == WordsPerPhase / 2) begin
          @(negedge clk);
          in_valid <= 1'b0;
          wait (pending == 0);
        end
        offer_random_access();
      end
    end

    steady = 1'b0;
    drain_port();
    repeat (20) @(posedge clk);
    $display("Run covered %0d accesses over %0d register setups; %0d words checked.",
             words_offered, setups_loaded, words_checked);
    $display("Included seed loads, 16/32-bit compute writes, all transposes, invalid sizes.");
    if (mismatches == 0 && pending == 0) begin
      $display("programmable_crc_engine: match");
    end else begin
      $display("programmable_crc_engine: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/pce_pkg.sv
src/pce_crc_core.sv
src/pce_read_fmt.sv
src/programmable_crc_engine.sv
sim/crc_port_checker.sv
sim/programmable_crc_engine_test.sv
